>>> rtl/cetm_pkg.sv
// ----------------------------------------------------------------------------
// cetm_pkg
// Types and codes shared by the eta/phi tower mapper core and its map logic.
// ----------------------------------------------------------------------------
package cetm_pkg;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ETA_RANGE   = 2'd1,
        ST_PHI_RANGE   = 2'd2,
        ST_LAYER_UNSET = 2'd3
    } t_status;

    localparam logic       CMD_DIRECT = 1'b0;
    localparam logic       CMD_PACKED = 1'b1;
    localparam logic [1:0] LAYER_EM   = 2'd0;
    localparam logic [1:0] LAYER_HAD  = 2'd1;

    typedef struct packed {
        logic        cmd;
        logic [6:0]  eta_bin;
        logic [6:0]  phi_bin;
        logic [1:0]  layer_sel;
        logic [31:0] packed_id;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [31:0] id_out;
        logic [6:0]  tower_eta;
        logic [5:0]  tower_phi;
        logic [6:0]  jet_eta;
        logic [5:0]  jet_phi;
    } t_out_beat;

    // Corner coordinates from the map logic
    typedef struct packed {
        logic [6:0] tower_eta;
        logic [5:0] tower_phi;
        logic [6:0] jet_eta;
        logic [5:0] jet_phi;
    } t_corner;

endpackage

>>> rtl/cetm_map.sv
// ----------------------------------------------------------------------------
// cetm_map
// Maps an in-range eta/phi bin and layer to trigger-tower and jet-element
// corners.
// ----------------------------------------------------------------------------
module cetm_map
    import cetm_pkg::*;
(
    input  logic [6:0] i_eta,
    input  logic [5:0] i_phi,
    input  logic       i_had,
    output t_corner    o_corner
);

    logic       outer_region;
    logic       mid_region;
    logic [6:0] tower_eta;
    logic [5:0] tower_phi;
    logic [6:0] jet_eta;
    logic [5:0] jet_phi;

    assign outer_region = (i_eta < 7'd17) || (i_eta >= 7'd81);
    assign mid_region   = (i_eta < 7'd24) || (i_eta >= 7'd74);

    // Trigger-tower eta; forward bins depend on the layer
    always_comb begin
        priority if (i_eta < 7'd17) begin
            if (i_had) begin
                tower_eta = (i_eta < 7'd9) ? 7'd0 : 7'd9;
            end else if (i_eta < 7'd5) begin
                tower_eta = 7'd0;
            end else if (i_eta < 7'd9) begin
                tower_eta = 7'd5;
            end else if (i_eta < 7'd13) begin
                tower_eta = 7'd9;
            end else begin
                tower_eta = 7'd13;
            end
        end else if (i_eta < 7'd18) begin
            tower_eta = 7'd17;
        end else if (i_eta < 7'd24) begin
            tower_eta = {i_eta[6:1], 1'b0};
        end else if (i_eta < 7'd74) begin
            tower_eta = i_eta;
        end else if (i_eta < 7'd80) begin
            tower_eta = {i_eta[6:1], 1'b0};
        end else if (i_eta < 7'd81) begin
            tower_eta = 7'd80;
        end else if (i_had) begin
            tower_eta = (i_eta < 7'd89) ? 7'd81 : 7'd89;
        end else if (i_eta < 7'd85) begin
            tower_eta = 7'd81;
        end else if (i_eta < 7'd89) begin
            tower_eta = 7'd85;
        end else if (i_eta < 7'd93) begin
            tower_eta = 7'd89;
        end else begin
            tower_eta = 7'd93;
        end
    end

    // Jet-element eta; central bins pair up starting at 25
    always_comb begin
        priority if (i_eta < 7'd17) begin
            jet_eta = 7'd0;
        end else if (i_eta >= 7'd81) begin
            jet_eta = 7'd81;
        end else if (i_eta < 7'd20) begin
            jet_eta = 7'd17;
        end else if (i_eta < 7'd22) begin
            jet_eta = 7'd20;
        end else if (i_eta < 7'd25) begin
            jet_eta = 7'd22;
        end else if (i_eta >= 7'd78) begin
            jet_eta = 7'd78;
        end else if (i_eta >= 7'd76) begin
            jet_eta = 7'd76;
        end else if (i_eta >= 7'd73) begin
            jet_eta = 7'd73;
        end else begin
            jet_eta = i_eta - {6'd0, ~i_eta[0]};
        end
    end

    always_comb begin
        if (outer_region) begin
            tower_phi = {i_phi[5:2], 2'b00};
            jet_phi   = {i_phi[5:2], 2'b00};
        end else begin
            tower_phi = mid_region ? {i_phi[5:1], 1'b0} : i_phi;
            jet_phi   = {i_phi[5:1], 1'b0};
        end
    end

    assign o_corner = {tower_eta, tower_phi, jet_eta, jet_phi};

endmodule

>>> rtl/calo_eta_phi_tower_mapper_core.sv
// ----------------------------------------------------------------------------
// calo_eta_phi_tower_mapper_core
// Checks a channel address (direct bins or packed id) and returns the packed
// id with trigger-tower and jet-element corner coordinates.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_beat  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall | o_out_beat (t_out_beat)
//
//  One beat per cycle sustained unless the output stalls; input register,
//  then result register, with range checks and corner maps between them.
//  Reset clears both valid flags; payload registers are not reset.
//  A stall on the output holds the result register and backs up into the
//  input register; the input stalls only when the input register is full
//  and cannot advance.
// ----------------------------------------------------------------------------
module calo_eta_phi_tower_mapper_core
    import cetm_pkg::*;
#(
    parameter int ETA_LIMIT = 98,
    parameter int PHI_LIMIT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_in_beat  r_in;
    logic      r_in_valid;
    t_out_beat r_out;
    t_out_beat n_out;
    logic      r_out_valid;

    logic        out_ready;
    logic        in_adv;
    logic        in_acc;
    logic [15:0] eta_full;
    logic [14:0] phi_full;
    logic [1:0]  layer_code;
    t_status     status;
    t_corner     corner;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign in_adv     = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_in.cmd == CMD_PACKED) begin
            eta_full   = r_in.packed_id[15:0];
            phi_full   = r_in.packed_id[30:16];
            layer_code = {1'b0, r_in.packed_id[31]};
        end else begin
            eta_full   = {9'd0, r_in.eta_bin};
            phi_full   = {8'd0, r_in.phi_bin};
            layer_code = r_in.layer_sel;
        end
    end

    // First failing check wins
    always_comb begin
        priority if (eta_full >= 16'(ETA_LIMIT)) begin
            status = ST_ETA_RANGE;
        end else if (phi_full >= 15'(PHI_LIMIT)) begin
            status = ST_PHI_RANGE;
        end else if (layer_code != LAYER_EM && layer_code != LAYER_HAD) begin
            status = ST_LAYER_UNSET;
        end else begin
            status = ST_OK;
        end
    end

    cetm_map u_map (
        .i_eta    (eta_full[6:0]),
        .i_phi    (phi_full[5:0]),
        .i_had    (layer_code == LAYER_HAD),
        .o_corner (corner)
    );

    always_comb begin
        n_out        = '0;
        n_out.status = status;
        if (status == ST_OK) begin
            n_out.id_out    = {layer_code[0], phi_full, eta_full};
            n_out.tower_eta = corner.tower_eta;
            n_out.tower_phi = corner.tower_phi;
            n_out.jet_eta   = corner.jet_eta;
            n_out.jet_phi   = corner.jet_phi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_beat;
        end
        if (in_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Error results carry no coordinates
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != ST_OK) |->
            (o_out_beat.id_out == '0 && o_out_beat.tower_eta == '0 &&
             o_out_beat.jet_eta == '0 && o_out_beat.tower_phi == '0 &&
             o_out_beat.jet_phi == '0))
        else $error("error result with nonzero coordinates");

    // Corners never lie above the channel they contain
    a_corner_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == ST_OK) |->
            (o_out_beat.tower_eta <= o_out_beat.id_out[6:0] &&
             o_out_beat.jet_eta <= o_out_beat.id_out[6:0] &&
             o_out_beat.tower_phi <= o_out_beat.id_out[21:16] &&
             {o_out_beat.jet_phi[0], o_out_beat.jet_phi} <= {1'b0, o_out_beat.id_out[21:16]}))
        else $error("corner beyond channel");

    // Input backs up only behind a full, blocked input register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without cause");

    // A beat advancing from the input register shows up in the result register next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv |=> r_out_valid)
        else $error("beat lost between stages");

endmodule
